// ===== rtl/core/smm_pkg.sv =====
package smm_pkg;

  localparam int DEF_NUM_SEGMENTS = 256;
  localparam int DEF_MAX_WORDS    = 1024;

  localparam int KIND_W = 3;
  localparam int SEG_W  = 8;
  localparam int OFF_W  = 10;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNMAP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PROGRAM = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ID   = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef struct packed {
    logic             mapped;
    logic [LEN_W-1:0] len;
  } seg_entry_t;

  typedef struct packed {
    logic       en;
    seg_entry_t entry;
  } seg_wr_t;

endpackage

// ===== rtl/core/smm_word_mem.sv =====
module smm_word_mem
  import smm_pkg::*;
#(
  parameter int AW = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [2**AW];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/smm_seg_table.sv =====
module smm_seg_table
  import smm_pkg::*;
#(
  parameter int NUM_SEGMENTS = DEF_NUM_SEGMENTS,
  localparam int IW = $clog2(NUM_SEGMENTS),
  localparam int CW = $clog2(NUM_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output seg_entry_t    rd_entry,
  input  seg_wr_t       wr,
  input  logic [IW-1:0] wr_idx,
  input  logic          alloc,
  output logic [IW-1:0] fresh_id,
  output logic          fresh_avail,
  output logic          seg0_mapped
);

  seg_entry_t    mem [NUM_SEGMENTS];
  seg_entry_t    rd_raw_r;
  logic          rd_valid_r;
  logic [CW-1:0] next_fresh_r;
  logic [CW-1:0] next_fresh_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_raw_r   <= mem[rd_idx];
      rd_valid_r <= CW'(rd_idx) < next_fresh_r;
    end
  end

  assign next_fresh_nxt = alloc ? next_fresh_r + CW'(1) : next_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_fresh_r <= '0;
    end else begin
      next_fresh_r <= next_fresh_nxt;
    end
  end

  assign rd_entry    = rd_valid_r ? rd_raw_r : '0;
  assign fresh_id    = IW'(next_fresh_r);
  assign fresh_avail = next_fresh_r != CW'(NUM_SEGMENTS);
  assign seg0_mapped = next_fresh_r != '0;

endmodule

// ===== rtl/core/smm_free_stack.sv =====
module smm_free_stack
  import smm_pkg::*;
#(
  parameter int NUM_SEGMENTS = DEF_NUM_SEGMENTS,
  localparam int IW = $clog2(NUM_SEGMENTS),
  localparam int CW = $clog2(NUM_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  output logic [IW-1:0] top_id,
  output logic          nonempty,
  output logic          full,
  input  logic          push,
  input  logic [IW-1:0] push_id,
  input  logic          pop
);

  logic [IW-1:0] mem [NUM_SEGMENTS];
  logic [IW-1:0] top_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[IW'(count_r)] <= push_id;
    end
    if (rd_en) begin
      top_r <= mem[IW'(count_r - CW'(1))];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top_id   = top_r;
  assign nonempty = count_r != '0;
  assign full     = count_r == CW'(NUM_SEGMENTS);

endmodule

// ===== rtl/core/segmented_memory_manager.sv =====
// Segmented word memory of a virtual machine.
// Command channel: a request (in_kind, in_segment_id, in_word_offset,
// in_store_value, in_map_words) transfers at a rising edge where start is high
// and busy is low. Kinds: load, store, map, unmap, program load into segment 0.
// Result channel: exactly one result per request, shown for one cycle with
// out_valid high: out_result_word (loaded word or new id) and out_status.
// The receiver cannot stall; a result is never held back.
// Steps per kind before the next transfer:
//   store, unmap, errors, unknown kinds: segment table lookup only
//   load: segment table read, then word memory read
//   map: zero fill writes one word per cycle
//   program load: copy reads and writes one word per cycle; an empty source
//     segment only rewrites the segment 0 entry, source segment 0 ends at lookup
// The result appears in the cycle after the last working cycle, while busy is
// already low. Segment state sits in synchronous memories with registered
// reads: the word memory, the segment table and the free id stack.
// Reset clears the fresh id counter and the free stack count; table entries at
// ids not yet handed out read as unmapped, so no clearing pass is needed.
module segmented_memory_manager
  import smm_pkg::*;
#(
  parameter int NUM_SEGMENTS = DEF_NUM_SEGMENTS,
  parameter int MAX_WORDS    = DEF_MAX_WORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SEG_W-1:0]  in_segment_id,
  input  logic [OFF_W-1:0]  in_word_offset,
  input  logic [WORD_W-1:0] in_store_value,
  input  logic [LEN_W-1:0]  in_map_words,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_result_word,
  output logic [STAT_W-1:0] out_status
);

  localparam int IW = $clog2(NUM_SEGMENTS);
  localparam longint unsigned DEPTH = longint'(NUM_SEGMENTS) * longint'(MAX_WORDS);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] SLOT_SIZE = AW'(MAX_WORDS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_ACCESS = 5'b00100,
    S_FILL   = 5'b01000,
    S_COPY   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]  words_r, words_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [IW-1:0]     id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [LEN_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              accept;
  logic              seg_ok;
  logic              off_ok;
  logic [IW-1:0]     id_sel;

  logic              wm_we;
  logic [AW-1:0]     wm_waddr;
  logic [WORD_W-1:0] wm_wdata;
  logic              wm_re;
  logic [AW-1:0]     wm_raddr;
  logic [WORD_W-1:0] wm_rdata;

  seg_entry_t        tbl_entry;
  seg_wr_t           tbl_wr;
  logic [IW-1:0]     tbl_wr_idx;
  logic              tbl_alloc;
  logic [IW-1:0]     fresh_id;
  logic              fresh_avail;
  logic              seg0_mapped;

  logic [IW-1:0]     stk_top;
  logic              stk_nonempty;
  logic              stk_full;
  logic              stk_push;
  logic              stk_pop;

  assign busy   = !state_r[0];
  assign accept = start && !busy;

  smm_word_mem #(
    .AW(AW)
  ) u_word_mem (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .re    (wm_re),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  smm_seg_table #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_seg_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_idx      (IW'(in_segment_id)),
    .rd_entry    (tbl_entry),
    .wr          (tbl_wr),
    .wr_idx      (tbl_wr_idx),
    .alloc       (tbl_alloc),
    .fresh_id    (fresh_id),
    .fresh_avail (fresh_avail),
    .seg0_mapped (seg0_mapped)
  );

  smm_free_stack #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .top_id   (stk_top),
    .nonempty (stk_nonempty),
    .full     (stk_full),
    .push     (stk_push),
    .push_id  (IW'(seg_r)),
    .pop      (stk_pop)
  );

  assign seg_ok = (32'(seg_r) < 32'(NUM_SEGMENTS)) && tbl_entry.mapped;
  assign off_ok = LEN_W'(off_r) < tbl_entry.len;
  assign id_sel = stk_nonempty ? stk_top : fresh_id;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    seg_nxt        = seg_r;
    off_nxt        = off_r;
    val_nxt        = val_r;
    words_nxt      = words_r;
    base_nxt       = base_r;
    id_nxt         = id_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;

    wm_we      = 1'b0;
    wm_waddr   = base_r + AW'(cnt_r);
    wm_wdata   = '0;
    wm_re      = 1'b0;
    wm_raddr   = base_r + AW'(off_r);
    tbl_wr     = '0;
    tbl_wr_idx = id_r;
    tbl_alloc  = 1'b0;
    stk_push   = 1'b0;
    stk_pop    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          seg_nxt   = in_segment_id;
          off_nxt   = in_word_offset;
          val_nxt   = in_store_value;
          words_nxt = in_map_words;
          base_nxt  = AW'(IW'(in_segment_id)) * SLOT_SIZE;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        out_word_nxt   = '0;
        out_status_nxt = ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
        unique case (kind_r)
          KIND_LOAD: begin
            if (!seg_ok || !off_ok) begin
              out_status_nxt = ST_BAD;
            end else begin
              wm_re         = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = S_ACCESS;
            end
          end
          KIND_STORE: begin
            if (!seg_ok || !off_ok) begin
              out_status_nxt = ST_BAD;
            end else begin
              wm_we    = 1'b1;
              wm_waddr = base_r + AW'(off_r);
              wm_wdata = val_r;
            end
          end
          KIND_MAP: begin
            if (32'(words_r) > 32'(MAX_WORDS)) begin
              out_status_nxt = ST_TOO_BIG;
            end else if (!stk_nonempty && !fresh_avail) begin
              out_status_nxt = ST_NO_ID;
            end else begin
              stk_pop       = stk_nonempty;
              tbl_alloc     = !stk_nonempty;
              id_nxt        = id_sel;
              base_nxt      = AW'(id_sel) * SLOT_SIZE;
              cnt_nxt       = '0;
              out_valid_nxt = 1'b0;
              state_nxt     = S_FILL;
            end
          end
          KIND_UNMAP: begin
            if (!seg_ok || seg_r == '0 || stk_full) begin
              out_status_nxt = ST_BAD;
            end else begin
              tbl_wr.en  = 1'b1;
              tbl_wr_idx = IW'(seg_r);
              stk_push   = 1'b1;
            end
          end
          KIND_PROGRAM: begin
            if (!seg_ok || !seg0_mapped) begin
              out_status_nxt = ST_BAD;
            end else if (seg_r != '0) begin
              len_nxt       = tbl_entry.len;
              cnt_nxt       = '0;
              pend_nxt      = 1'b0;
              out_valid_nxt = 1'b0;
              state_nxt     = S_COPY;
            end
          end
          default: begin
          end
        endcase
      end
      S_ACCESS: begin
        out_word_nxt   = wm_rdata;
        out_status_nxt = ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_FILL: begin
        if (cnt_r == words_r) begin
          tbl_wr.en           = 1'b1;
          tbl_wr.entry.mapped = 1'b1;
          tbl_wr.entry.len    = words_r;
          tbl_wr_idx          = id_r;
          out_word_nxt        = WORD_W'(id_r);
          out_status_nxt      = ST_OK;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          wm_we   = 1'b1;
          cnt_nxt = cnt_r + LEN_W'(1);
        end
      end
      S_COPY: begin
        wm_raddr = base_r + AW'(cnt_r);
        if (pend_r) begin
          wm_we    = 1'b1;
          wm_waddr = AW'(pend_idx_r);
          wm_wdata = wm_rdata;
        end
        if (cnt_r != len_r) begin
          wm_re        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r;
          cnt_nxt      = cnt_r + LEN_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            tbl_wr.en           = 1'b1;
            tbl_wr.entry.mapped = 1'b1;
            tbl_wr.entry.len    = len_r;
            tbl_wr_idx          = '0;
            out_word_nxt        = '0;
            out_status_nxt      = ST_OK;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    seg_r        <= seg_nxt;
    off_r        <= off_nxt;
    val_r        <= val_nxt;
    words_r      <= words_nxt;
    base_r       <= base_nxt;
    id_r         <= id_nxt;
    len_r        <= len_nxt;
    cnt_r        <= cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_status      = out_status_r;

endmodule
